FILE: src/cltok_pkg.sv
// Package with the types, codes and helper functions of the command line tokenizer.
`default_nettype none

package cltok_pkg;

    localparam int DefMaxArgs = 255;
    localparam int ResultDepth = 4;

    localparam logic [7:0] EscapeReset = 8'h2A;
    localparam logic [7:0] AsteriskByte = 8'h2A;
    localparam logic [7:0] QuoteByte = 8'h22;
    localparam logic [7:0] EscByte = 8'h1B;
    localparam logic [7:0] NewlineByte = 8'h0A;
    localparam logic [7:0] NbspByte = 8'hA0;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END_ARG = 2'd1;
    localparam logic [1:0] KIND_END_LINE = 2'd2;

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_PLAIN = 2'd1;
    localparam logic [1:0] MODE_QUOTED = 2'd2;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] arg_data;
        logic [7:0] arg_number;
        logic       was_quoted;
        logic       last_result;
    } t_result;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) || (b == 8'h0C) ||
               (b == 8'h0D) || (b == 8'h20) || (b == NbspByte);
    endfunction

    function automatic logic [7:0] translate(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if ((b == 8'h65) || (b == 8'h45)) begin
            r = EscByte;
        end else if ((b == 8'h6E) || (b == 8'h4E)) begin
            r = NewlineByte;
        end
        return r;
    endfunction

    function automatic t_result make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [7:0] num, input logic quoted);
        t_result r;
        r.item_kind = kind;
        r.arg_data = data;
        r.arg_number = num;
        r.was_quoted = quoted;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/cltok_if.sv
// Interfaces of the input byte channel and the result channel.
`default_nettype none

interface cltok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface cltok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] arg_data;
    logic [7:0] arg_number;
    logic       was_quoted;
    logic       last_result;

    modport source (output valid, output item_kind, output arg_data, output arg_number,
                    output was_quoted, output last_result, input ready);
    modport sink (input valid, input item_kind, input arg_data, input arg_number,
                  input was_quoted, input last_result, output ready);
endinterface

`default_nettype wire

FILE: src/command_line_tokenizer_core.sv
// Command line tokenizer: splits a byte stream into argument bytes and markers.
//
// The input channel i_in carries one byte of a command line per word, with
// end_of_line set on the final byte. The output channel o_out carries result
// words: argument bytes after escape translation, end-of-argument markers with
// the argument index and quoted flag, and one end-of-line marker with the
// argument count. last_result marks the final result word of an input byte.
// One input byte yields zero to four result words. They are computed in the
// cycle the byte is accepted and appear on o_out in the next cycle, one per
// cycle, from a four-entry result buffer. A new byte is accepted while the
// last result word of the previous byte is being taken, so a byte with one
// result sustains one word per cycle. The escape byte register is written
// through i_cfg_we and i_cfg_data; the user must write it only while the block
// is idle, not enforced by the block. Synchronous active-low reset empties the
// result buffer, returns the scanner to the state between arguments and sets
// the escape byte to an asterisk. When the receiver stalls, the buffer holds
// its words and the input is not accepted until the buffer drains.
`default_nettype none

module command_line_tokenizer_core #(
    parameter int MAX_ARGS = cltok_pkg::DefMaxArgs
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    cltok_in_if.sink        i_in,
    cltok_out_if.source     o_out
);
    import cltok_pkg::*;

    localparam logic [7:0] ArgLimit = (MAX_ARGS > 255) ? 8'd255 : 8'(MAX_ARGS);

    logic [7:0] r_escape;
    logic [1:0] r_mode;
    logic       r_esc_pend;
    logic       r_quote_pend;
    logic [7:0] r_argc;
    t_result    r_buf [ResultDepth];
    logic [2:0] r_cnt;

    logic [1:0] n_mode;
    logic       n_esc_pend;
    logic       n_quote_pend;
    logic [7:0] n_argc;
    t_result    n_buf [ResultDepth];
    logic [2:0] n_cnt;

    logic accept;
    logic take;

    assign take = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign accept = i_in.valid && i_in.ready;

    assign o_out.valid = (r_cnt != 3'd0);
    assign o_out.item_kind = r_buf[0].item_kind;
    assign o_out.arg_data = r_buf[0].arg_data;
    assign o_out.arg_number = r_buf[0].arg_number;
    assign o_out.was_quoted = r_buf[0].was_quoted;
    assign o_out.last_result = r_buf[0].last_result;

    always_comb begin
        logic [7:0] b;
        logic       eol;
        logic       done;
        b = i_in.line_byte;
        eol = i_in.end_of_line;
        done = 1'b0;
        n_mode = r_mode;
        n_esc_pend = r_esc_pend;
        n_quote_pend = r_quote_pend;
        n_argc = r_argc;
        n_cnt = 3'd0;
        for (int i = 0; i < ResultDepth; i++) begin
            n_buf[i] = '0;
        end

        if (r_mode == MODE_QUOTED) begin
            if (r_quote_pend) begin
                n_quote_pend = 1'b0;
                if (is_blank(b)) begin
                    n_buf[n_cnt[1:0]] = make_result(KIND_END_ARG, 8'h00, n_argc, 1'b1);
                    n_cnt = n_cnt + 3'd1;
                    n_mode = MODE_BETWEEN;
                    done = 1'b1;
                end else if (r_escape == QuoteByte) begin
                    n_buf[n_cnt[1:0]] = make_result(KIND_DATA, translate(b), n_argc, 1'b1);
                    n_cnt = n_cnt + 3'd1;
                    done = 1'b1;
                end else begin
                    n_buf[n_cnt[1:0]] = make_result(KIND_DATA, QuoteByte, n_argc, 1'b1);
                    n_cnt = n_cnt + 3'd1;
                end
            end
            if (!done) begin
                if (r_esc_pend) begin
                    n_esc_pend = 1'b0;
                    n_buf[n_cnt[1:0]] = make_result(KIND_DATA, translate(b), n_argc, 1'b1);
                    n_cnt = n_cnt + 3'd1;
                end else if (b == QuoteByte) begin
                    if (eol) begin
                        n_buf[n_cnt[1:0]] = make_result(KIND_END_ARG, 8'h00, n_argc, 1'b1);
                        n_cnt = n_cnt + 3'd1;
                        n_mode = MODE_BETWEEN;
                    end else begin
                        n_quote_pend = 1'b1;
                    end
                end else if ((b == AsteriskByte) || (b == r_escape)) begin
                    n_esc_pend = 1'b1;
                end else begin
                    n_buf[n_cnt[1:0]] = make_result(KIND_DATA, b, n_argc, 1'b1);
                    n_cnt = n_cnt + 3'd1;
                end
            end
        end else if (r_mode == MODE_PLAIN) begin
            if (is_blank(b)) begin
                n_buf[n_cnt[1:0]] = make_result(KIND_END_ARG, 8'h00, n_argc, 1'b0);
                n_cnt = n_cnt + 3'd1;
                n_mode = MODE_BETWEEN;
            end else begin
                n_buf[n_cnt[1:0]] = make_result(KIND_DATA, b, n_argc, 1'b0);
                n_cnt = n_cnt + 3'd1;
            end
        end else begin
            if (b == QuoteByte) begin
                if (r_argc < ArgLimit) begin
                    n_argc = r_argc + 8'd1;
                end
                n_mode = MODE_QUOTED;
            end else if (!is_blank(b)) begin
                if (r_argc < ArgLimit) begin
                    n_argc = r_argc + 8'd1;
                end
                n_mode = MODE_PLAIN;
                n_buf[n_cnt[1:0]] = make_result(KIND_DATA, b, n_argc, 1'b0);
                n_cnt = n_cnt + 3'd1;
            end
        end

        if (eol) begin
            if (n_mode != MODE_BETWEEN) begin
                n_buf[n_cnt[1:0]] = make_result(KIND_END_ARG, 8'h00, n_argc,
                                                n_mode == MODE_QUOTED);
                n_cnt = n_cnt + 3'd1;
            end
            n_buf[n_cnt[1:0]] = make_result(KIND_END_LINE, 8'h00, n_argc, 1'b0);
            n_cnt = n_cnt + 3'd1;
            n_mode = MODE_BETWEEN;
            n_esc_pend = 1'b0;
            n_quote_pend = 1'b0;
            n_argc = 8'd0;
        end

        for (int i = 0; i < ResultDepth; i++) begin
            if (n_cnt == 3'(i + 1)) begin
                n_buf[i].last_result = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= EscapeReset;
        end else if (i_cfg_we) begin
            r_escape <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_esc_pend <= 1'b0;
            r_quote_pend <= 1'b0;
            r_argc <= 8'd0;
            r_cnt <= 3'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_esc_pend <= n_esc_pend;
            r_quote_pend <= n_quote_pend;
            r_argc <= n_argc;
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < ResultDepth; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end else if (take) begin
            for (int i = 0; i < ResultDepth - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result buffer count out of range");

    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_cnt == 3'd0) || ((r_cnt == 3'd1) && take))
        else $error("input word accepted while results are pending");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_result) |-> (r_cnt == 3'd1))
        else $error("last result word is not the final buffered word");

    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.item_kind == KIND_END_LINE)) |-> o_out.last_result)
        else $error("end of line marker is not the last result");

    a_eol_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.end_of_line) |=>
            ((r_mode == MODE_BETWEEN) && (r_argc == 8'd0) && !r_esc_pend && !r_quote_pend))
        else $error("scanner state not cleared after end of line");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_command_line_tokenizer_core.sv
// Self-checking testbench of the command line tokenizer core.
`timescale 1ns / 100ps

module tb_command_line_tokenizer_core;
    import cltok_pkg::*;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       eol;
        logic       pinned;
        t_result    word;
    } t_stim_row;

    localparam t_result NoWord = '0;

    localparam t_stim_row DirectedRows [25] = '{
        '{8'h61, 1'b0, 1'b1, '{KIND_DATA, 8'h61, 8'd1, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{KIND_DATA, 8'hFF, 8'd1, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b1, '{KIND_DATA, 8'h00, 8'd1, 1'b0, 1'b1}},
        '{QuoteByte, 1'b0, 1'b1, '{KIND_DATA, QuoteByte, 8'd1, 1'b0, 1'b1}},
        '{NbspByte, 1'b0, 1'b1, '{KIND_END_ARG, 8'h00, 8'd1, 1'b0, 1'b1}},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{AsteriskByte, 1'b0, 1'b0, NoWord},
        '{8'h65, 1'b0, 1'b1, '{KIND_DATA, EscByte, 8'd2, 1'b1, 1'b1}},
        '{AsteriskByte, 1'b0, 1'b0, NoWord},
        '{8'h4E, 1'b0, 1'b1, '{KIND_DATA, NewlineByte, 8'd2, 1'b1, 1'b1}},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{8'h71, 1'b0, 1'b0, NoWord},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{8'h09, 1'b0, 1'b1, '{KIND_END_ARG, 8'h00, 8'd2, 1'b1, 1'b1}},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{8'h7A, 1'b0, 1'b0, NoWord},
        '{QuoteByte, 1'b1, 1'b0, NoWord},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{8'h6B, 1'b0, 1'b0, NoWord},
        '{AsteriskByte, 1'b1, 1'b0, NoWord},
        '{8'h20, 1'b1, 1'b1, '{KIND_END_LINE, 8'h00, 8'd0, 1'b0, 1'b1}},
        '{8'h77, 1'b1, 1'b0, NoWord},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{QuoteByte, 1'b0, 1'b0, NoWord},
        '{8'h61, 1'b1, 1'b0, NoWord}
    };

    localparam logic [7:0] Separators [7] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, NbspByte};
    localparam logic [7:0] EscapeLetters [4] = '{8'h65, 8'h45, 8'h6E, 8'h4E};
    localparam logic [7:0] EscapeSettings [4] = '{QuoteByte, 8'h00, 8'hFF, 8'h5C};
    localparam int ArgLimit = (DefMaxArgs > 255) ? 255 : DefMaxArgs;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    cltok_in_if  in_if ();
    cltok_out_if out_if ();

    command_line_tokenizer_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    logic [1:0] scan_state = MODE_BETWEEN;
    logic       esc_armed = 1'b0;
    logic       quote_armed = 1'b0;
    logic [7:0] arg_index = 8'd0;
    logic [7:0] escape_setting = EscapeReset;

    t_result    expected_words[$];
    t_result    burst_words[$];
    logic [7:0] line_text[$];
    int         error_count = 0;
    int         bytes_sent = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    function automatic logic is_separator(input logic [7:0] b);
        foreach (Separators[i]) begin
            if (b == Separators[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic is_escape(input logic [7:0] b);
        return (b == AsteriskByte) || (b == escape_setting);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        if ((b == 8'h65) || (b == 8'h45)) begin
            return EscByte;
        end
        if ((b == 8'h6E) || (b == 8'h4E)) begin
            return NewlineByte;
        end
        return b;
    endfunction

    function automatic void emit_word(input logic [1:0] kind, input logic [7:0] data);
        t_result w;
        w.item_kind = kind;
        w.arg_data = data;
        w.arg_number = arg_index;
        w.was_quoted = (scan_state == MODE_QUOTED);
        w.last_result = 1'b0;
        burst_words.push_back(w);
    endfunction

    function automatic void close_arg();
        emit_word(KIND_END_ARG, 8'h00);
        scan_state = MODE_BETWEEN;
    endfunction

    function automatic void open_arg(input logic [1:0] mode);
        if (arg_index < ArgLimit) begin
            arg_index = arg_index + 8'd1;
        end
        scan_state = mode;
    endfunction

    // Works out the result words of one accepted byte into burst_words.
    function automatic void tokenize_byte(input logic [7:0] b, input logic eol);
        logic finished;
        burst_words.delete();
        finished = 1'b0;
        if (scan_state == MODE_QUOTED) begin
            if (quote_armed) begin
                quote_armed = 1'b0;
                if (is_separator(b)) begin
                    close_arg();
                    finished = 1'b1;
                end else if (is_escape(QuoteByte)) begin
                    emit_word(KIND_DATA, unescape(b));
                    finished = 1'b1;
                end else begin
                    emit_word(KIND_DATA, QuoteByte);
                end
            end
            if (!finished) begin
                if (esc_armed) begin
                    esc_armed = 1'b0;
                    emit_word(KIND_DATA, unescape(b));
                end else if (b == QuoteByte) begin
                    if (eol) begin
                        close_arg();
                    end else begin
                        quote_armed = 1'b1;
                    end
                end else if (is_escape(b)) begin
                    esc_armed = 1'b1;
                end else begin
                    emit_word(KIND_DATA, b);
                end
            end
        end else if (scan_state == MODE_PLAIN) begin
            if (is_separator(b)) begin
                close_arg();
            end else begin
                emit_word(KIND_DATA, b);
            end
        end else begin
            if (b == QuoteByte) begin
                open_arg(MODE_QUOTED);
            end else if (!is_separator(b)) begin
                open_arg(MODE_PLAIN);
                emit_word(KIND_DATA, b);
            end
        end
        if (eol) begin
            if (scan_state != MODE_BETWEEN) begin
                close_arg();
            end
            emit_word(KIND_END_LINE, 8'h00);
            esc_armed = 1'b0;
            quote_armed = 1'b0;
            arg_index = 8'd0;
        end
        if (burst_words.size() > 0) begin
            burst_words[burst_words.size() - 1].last_result = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_separator();
        return Separators[$urandom_range(0, 6)];
    endfunction

    function automatic logic [7:0] pick_content();
        case ($urandom_range(0, 11))
            0: return EscapeLetters[$urandom_range(0, 3)];
            1: return AsteriskByte;
            2: return escape_setting;
            3: return QuoteByte;
            4: return pick_separator();
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eol, input logic pinned,
                             input t_result typed);
        int gap;
        gap = 0;
        while ((gap < 20) && ($urandom_range(0, 99) < send_idle_pct)) begin
            gap++;
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.line_byte <= b;
        in_if.end_of_line <= eol;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
        tokenize_byte(b, eol);
        if (pinned) begin
            expected_words.push_back(typed);
        end else begin
            foreach (burst_words[i]) begin
                expected_words.push_back(burst_words[i]);
            end
        end
    endtask

    task automatic send_line();
        foreach (line_text[i]) begin
            send_byte(line_text[i], i == line_text.size() - 1, 1'b0, NoWord);
        end
    endtask

    task automatic send_random_line();
        int shape;
        int n_args;
        int len;
        line_text.delete();
        shape = $urandom_range(0, 9);
        if (shape < 2) begin
            len = $urandom_range(1, 12);
            repeat (len) line_text.push_back((shape == 0) ? 8'($urandom) : pick_content());
        end else begin
            n_args = $urandom_range(1, 6);
            for (int a = 0; a < n_args; a++) begin
                if (a > 0) begin
                    repeat ($urandom_range(1, 2)) line_text.push_back(pick_separator());
                end
                len = $urandom_range(0, 6);
                if ($urandom_range(0, 1) == 1) begin
                    line_text.push_back(QuoteByte);
                    repeat (len) line_text.push_back(pick_content());
                    if ($urandom_range(0, 7) != 0) begin
                        line_text.push_back(QuoteByte);
                    end
                end else begin
                    line_text.push_back(8'($urandom_range(8'h23, 8'h7E)));
                    repeat (len) line_text.push_back(pick_content());
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                line_text.push_back(pick_separator());
            end
        end
        send_line();
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: kind %0d data %0h number %0d",
                       out_if.item_kind, out_if.arg_data, out_if.arg_number);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("item_kind", want.item_kind, out_if.item_kind);
                check_field("arg_data", want.arg_data, out_if.arg_data);
                check_field("arg_number", want.arg_number, out_if.arg_number);
                check_field("was_quoted", want.was_quoted, out_if.was_quoted);
                check_field("last_result", want.last_result, out_if.last_result);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_command_line_tokenizer_core: errors");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= 8'h00;
        in_if.valid <= 1'b0;
        in_if.line_byte <= 8'h00;
        in_if.end_of_line <= 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 77;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DirectedRows[r]) begin
            send_byte(DirectedRows[r].line_byte, DirectedRows[r].eol, DirectedRows[r].pinned,
                      DirectedRows[r].word);
        end

        for (int p = 0; p < 4; p++) begin
            drain_results();
            repeat (6) @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_data <= EscapeSettings[p];
            @(posedge i_clk);
            cfg_we <= 1'b0;
            escape_setting = EscapeSettings[p];
            send_idle_pct = (p == 0) ? 38 : (p == 1) ? 77 : 0;
            recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 38 : 0;
            bytes_sent = 0;
            while (bytes_sent < 50) begin
                send_random_line();
                if ($urandom_range(0, 7) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_command_line_tokenizer_core: clean");
        end else begin
            $display("tb_command_line_tokenizer_core: errors");
        end
        $finish;
    end

endmodule
